// File: rtl/core/trc_pkg.sv
// Shared opcodes, error codes and bundle types of the tiny register CPU core.
package trc_pkg;

    // Opcode bytes; any byte above the last one acts as a one-byte no-op.
    localparam logic [7:0] OP_NOP  = 8'd0;
    localparam logic [7:0] OP_HALT = 8'd1;
    localparam logic [7:0] OP_MOV  = 8'd2;
    localparam logic [7:0] OP_ADD  = 8'd3;
    localparam logic [7:0] OP_SUB  = 8'd4;
    localparam logic [7:0] OP_AND  = 8'd5;
    localparam logic [7:0] OP_OR   = 8'd6;
    localparam logic [7:0] OP_XOR  = 8'd7;
    localparam logic [7:0] OP_JMP  = 8'd8;
    localparam logic [7:0] OP_JZ   = 8'd9;
    localparam logic [7:0] OP_EQU  = 8'd10;
    localparam logic [7:0] OP_SHFT = 8'd11;
    localparam logic [7:0] OP_LDI  = 8'd12;
    localparam logic [7:0] OP_DEO  = 8'd13;
    localparam logic [7:0] OP_CALL = 8'd14;
    localparam logic [7:0] OP_RET  = 8'd15;

    // Fault codes reported while the core is stopped.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_REG   = 3'd1;
    localparam logic [2:0] ERR_PC_END    = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd4;

    // Instruction lengths in bytes.
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // Last legal byte address.
    localparam logic [16:0] ADDR_LAST = 17'h0ffff;

    // One instruction beat.
    typedef struct packed {
        logic [7:0] func;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
    } t_instr;

    // Architectural control state kept in the top level.
    typedef struct packed {
        logic [15:0] pc;
        logic        stopped;
        logic [2:0]  fault;
    } t_core_state;

    // Register file write request.
    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
    } t_reg_wr;

    // Return stack request.
    typedef struct packed {
        logic        push;
        logic        pop;
        logic [15:0] data;
    } t_stack_ctl;

    // One result beat.
    typedef struct packed {
        logic [15:0] fetch_addr;
        logic        halted;
        logic [2:0]  error_code;
        logic        dev_write;
        logic [7:0]  dev_port;
        logic [7:0]  dev_value;
    } t_result;

    // Everything the execute logic decides for one instruction.
    typedef struct packed {
        t_core_state nxt;
        t_reg_wr     wr;
        t_stack_ctl  stk;
        t_result     rsp;
    } t_exec_out;

endpackage

// File: rtl/core/trc_regfile.sv
// General purpose register file with two registered read ports and write bypass.
module trc_regfile import trc_pkg::*; #(
    parameter int NUM_REGS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [$clog2(NUM_REGS)-1:0] i_raddr_a,
    input  logic [$clog2(NUM_REGS)-1:0] i_raddr_b,
    input  t_reg_wr                     i_wr,
    output logic [7:0]                  o_rdata_a,
    output logic [7:0]                  o_rdata_b
);

    localparam int IW = $clog2(NUM_REGS);

    logic [7:0]          r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    logic [7:0]          r_a_q;
    logic [7:0]          r_b_q;
    logic                r_a_vld;
    logic                r_b_vld;
    logic                r_a_hit;
    logic                r_b_hit;
    logic [7:0]          r_wq;
    logic [IW-1:0]       waddr;

    assign waddr = i_wr.addr[IW-1:0];

    // Storage write; an entry reads as zero until it is first written.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[waddr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.we) begin
            r_vld[waddr] <= 1'b1;
        end
    end

    // Registered reads, taken when a beat enters the input register.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_a_q <= r_mem[i_raddr_a];
            r_b_q <= r_mem[i_raddr_b];
            r_wq  <= i_wr.data;
        end
    end

    // Flags that pick the write made on the same edge as the read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_a_hit <= 1'b0;
            r_b_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_a_vld <= r_vld[i_raddr_a];
            r_b_vld <= r_vld[i_raddr_b];
            r_a_hit <= i_wr.we && (waddr == i_raddr_a);
            r_b_hit <= i_wr.we && (waddr == i_raddr_b);
        end
    end

    assign o_rdata_a = r_a_hit ? r_wq : (r_a_vld ? r_a_q : 8'd0);
    assign o_rdata_b = r_b_hit ? r_wq : (r_b_vld ? r_b_q : 8'd0);

endmodule

// File: rtl/core/trc_stack.sv
// Return address stack: top entry in a register, the rest in a memory.
module trc_stack import trc_pkg::*; #(
    parameter int STACK_DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_stack_ctl                         i_ctl,
    output logic [$clog2(STACK_DEPTH+1)-1:0]   o_count,
    output logic [15:0]                        o_top
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [15:0]   r_mem [STACK_DEPTH];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [15:0]   r_top;
    logic [15:0]   r_rd;
    logic [15:0]   r_byp_val;
    logic          r_byp_sel;
    logic [CW-1:0] wr_idx;
    logic [CW-1:0] rd_idx;
    logic [15:0]   below;

    // Entry under the top: fresh from the last push, else from the memory.
    assign below = r_byp_sel ? r_byp_val : r_rd;

    always_comb begin
        priority if (i_ctl.push) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.pop) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    assign wr_idx = r_count - CW'(1);
    assign rd_idx = n_count - CW'(2);

    // Memory write of the old top on push, registered read of the entry below.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && (r_count != '0)) begin
            r_mem[wr_idx[AW-1:0]] <= r_top;
        end
        r_rd      <= r_mem[rd_idx[AW-1:0]];
        r_byp_val <= r_top;
    end

    // Top of stack register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_top <= i_ctl.data;
        end else if (i_ctl.pop) begin
            r_top <= below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_byp_sel <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_byp_sel <= i_ctl.push;
        end
    end

    assign o_count = r_count;
    assign o_top   = r_top;

    // The depth never goes past the configured size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("return stack count beyond depth");

    // Push is never asked for on a full stack, pop never on an empty one.
    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((i_ctl.push && (r_count == CW'(STACK_DEPTH))) ||
          (i_ctl.pop && (r_count == '0))))
        else $error("return stack push when full or pop when empty");

endmodule

// File: rtl/core/trc_exec.sv
// Instruction decode, ALU and next-state logic for one instruction.
module trc_exec import trc_pkg::*; #(
    parameter int STACK_DEPTH = 256,
    parameter int NUM_REGS    = 8
) (
    input  t_instr                             i_instr,
    input  t_core_state                        i_state,
    input  logic [7:0]                         i_opnd_a,
    input  logic [7:0]                         i_opnd_b,
    input  logic [$clog2(STACK_DEPTH+1)-1:0]   i_count,
    input  logic [15:0]                        i_top,
    output t_exec_out                          o_exec
);

    localparam int          CW   = $clog2(STACK_DEPTH + 1);
    localparam logic [8:0]  NREG = 9'(NUM_REGS);

    logic        bad_one;
    logic        bad_two;
    logic        bad_three;
    logic [7:0]  alu;
    logic [2:0]  len;
    logic        seq;
    logic [16:0] next_seq;
    logic        dev_wr;
    logic [7:0]  dev_port;
    logic [7:0]  dev_val;
    t_core_state nxt;
    t_reg_wr     wr;
    t_stack_ctl  stk;

    assign bad_one   = {1'b0, i_instr.byte_one} >= NREG;
    assign bad_two   = {1'b0, i_instr.byte_two} >= NREG;
    assign bad_three = {1'b0, i_instr.byte_three} >= NREG;

    // Three-operand ALU.
    always_comb begin
        unique case (i_instr.func)
            OP_ADD:  alu = i_opnd_a + i_opnd_b;
            OP_SUB:  alu = i_opnd_a - i_opnd_b;
            OP_AND:  alu = i_opnd_a & i_opnd_b;
            OP_OR:   alu = i_opnd_a | i_opnd_b;
            OP_XOR:  alu = i_opnd_a ^ i_opnd_b;
            default: alu = {7'd0, i_opnd_a == i_opnd_b};
        endcase
    end

    // Decode and state update.
    always_comb begin
        nxt      = i_state;
        wr       = '{we: 1'b0, addr: i_instr.byte_one, data: alu};
        stk      = '{push: 1'b0, pop: 1'b0, data: i_state.pc + 16'd3};
        len      = LEN_ONE;
        seq      = 1'b0;
        dev_wr   = 1'b0;
        dev_port = 8'd0;
        dev_val  = 8'd0;
        if (!i_state.stopped) begin
            unique case (i_instr.func)
                OP_HALT: begin
                    nxt.stopped = 1'b1;
                end
                OP_MOV: begin
                    if (bad_one || bad_two) begin
                        nxt.stopped = 1'b1;
                        nxt.fault   = ERR_BAD_REG;
                    end else begin
                        wr.we   = 1'b1;
                        wr.data = i_opnd_a;
                        len     = LEN_THREE;
                        seq     = 1'b1;
                    end
                end
                OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_EQU: begin
                    if (bad_one || bad_two || bad_three) begin
                        nxt.stopped = 1'b1;
                        nxt.fault   = ERR_BAD_REG;
                    end else begin
                        wr.we = 1'b1;
                        len   = LEN_FOUR;
                        seq   = 1'b1;
                    end
                end
                OP_JMP: begin
                    nxt.pc = {i_instr.byte_one, i_instr.byte_two};
                end
                OP_JZ: begin
                    if (bad_one) begin
                        nxt.stopped = 1'b1;
                        nxt.fault   = ERR_BAD_REG;
                    end else if (i_opnd_a == 8'd0) begin
                        nxt.pc = {i_instr.byte_two, i_instr.byte_three};
                    end else begin
                        len = LEN_FOUR;
                        seq = 1'b1;
                    end
                end
                OP_SHFT: begin
                    if (bad_one) begin
                        nxt.stopped = 1'b1;
                        nxt.fault   = ERR_BAD_REG;
                    end else begin
                        wr.we   = 1'b1;
                        wr.data = (i_instr.byte_two == 8'd0) ? (i_opnd_a >> 1)
                                                             : (i_opnd_a << 1);
                        len     = LEN_THREE;
                        seq     = 1'b1;
                    end
                end
                OP_LDI: begin
                    if (bad_one) begin
                        nxt.stopped = 1'b1;
                        nxt.fault   = ERR_BAD_REG;
                    end else begin
                        wr.we   = 1'b1;
                        wr.data = i_instr.byte_two;
                        len     = LEN_THREE;
                        seq     = 1'b1;
                    end
                end
                OP_DEO: begin
                    if (bad_one || bad_two) begin
                        nxt.stopped = 1'b1;
                        nxt.fault   = ERR_BAD_REG;
                    end else begin
                        dev_wr   = 1'b1;
                        dev_port = i_opnd_a;
                        dev_val  = i_opnd_b;
                        len      = LEN_THREE;
                        seq      = 1'b1;
                    end
                end
                OP_CALL: begin
                    if (i_count == CW'(STACK_DEPTH)) begin
                        nxt.stopped = 1'b1;
                        nxt.fault   = ERR_OVERFLOW;
                    end else begin
                        stk.push = 1'b1;
                        nxt.pc   = {i_instr.byte_one, i_instr.byte_two};
                    end
                end
                OP_RET: begin
                    if (i_count == '0) begin
                        nxt.stopped = 1'b1;
                        nxt.fault   = ERR_UNDERFLOW;
                    end else begin
                        stk.pop = 1'b1;
                        nxt.pc  = i_top;
                    end
                end
                default: begin
                    seq = 1'b1;
                end
            endcase
        end

        // Fall-through instructions advance, or stop when they run off the end.
        next_seq = {1'b0, i_state.pc} + {14'd0, len};
        if (seq) begin
            if (next_seq > ADDR_LAST) begin
                nxt.stopped = 1'b1;
                nxt.fault   = ERR_PC_END;
            end else begin
                nxt.pc = next_seq[15:0];
            end
        end
    end

    always_comb begin
        o_exec.nxt = nxt;
        o_exec.wr  = wr;
        o_exec.stk = stk;
        o_exec.rsp = '{fetch_addr: nxt.pc, halted: nxt.stopped,
                       error_code: nxt.fault, dev_write: dev_wr,
                       dev_port: dev_port, dev_value: dev_val};
    end

endmodule

// File: rtl/core/tiny_register_cpu_core.sv
// Top level of the tiny register CPU core: input register, execute stage, result register.
//
// The core runs one instruction of a small 8-bit register machine per input beat.
// Input channel (i_valid/o_ready): the opcode byte found at the last reported
// fetch address plus the three bytes after it. Output channel (o_valid/i_ready):
// the next fetch address, the halted flag, the error code and an optional
// device write. Every input beat yields exactly one output beat, in order.
// An accepted beat is held in the input register and executes from there; its result
// is registered in the result register, from which it leaves. Throughput is one
// instruction per cycle while the receiver keeps up; the register file read
// ports, which are sampled as a beat enters and bypass the write made on that
// same edge, keep dependent instructions back to back.
// When the receiver stalls, the result register holds its beat and the
// instruction in the input register waits behind it; o_ready stays high while
// that input register is empty or is about to drain.
// Reset (synchronous, active low) clears the program counter, the registers,
// the stack depth and the stopped and fault status. Once stopped, the core
// repeats its fetch address and fault for every further beat.
module tiny_register_cpu_core import trc_pkg::*; #(
    parameter int STACK_DEPTH = 256,
    parameter int NUM_REGS    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_func,
    input  logic [7:0]  i_byte_one,
    input  logic [7:0]  i_byte_two,
    input  logic [7:0]  i_byte_three,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_fetch_addr,
    output logic        o_halted,
    output logic [2:0]  o_error_code,
    output logic        o_dev_write,
    output logic [7:0]  o_dev_port,
    output logic [7:0]  o_dev_value
);

    localparam int IW = $clog2(NUM_REGS);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic          r_in_valid;
    t_instr        r_instr;
    t_core_state   r_state;
    logic          r_out_valid;
    t_result       r_out;
    logic          in_acc;
    logic          fire;
    logic [IW-1:0] raddr_a;
    logic [IW-1:0] raddr_b;
    logic [7:0]    opnd_a;
    logic [7:0]    opnd_b;
    logic [CW-1:0] count;
    logic [15:0]   top;
    t_exec_out     exec;
    t_reg_wr       wr_g;
    t_stack_ctl    stk_g;

    // Handshake: the execute stage moves when the result register can take a beat.
    assign fire    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;
    assign in_acc  = i_valid && o_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_instr <= '{func: i_func, byte_one: i_byte_one,
                         byte_two: i_byte_two, byte_three: i_byte_three};
        end
    end

    // Read port selection: port A feeds the first source, port B the second.
    always_comb begin
        if ((i_func == OP_JZ) || (i_func == OP_SHFT) || (i_func == OP_DEO)) begin
            raddr_a = i_byte_one[IW-1:0];
        end else begin
            raddr_a = i_byte_two[IW-1:0];
        end
        if (i_func == OP_DEO) begin
            raddr_b = i_byte_two[IW-1:0];
        end else begin
            raddr_b = i_byte_three[IW-1:0];
        end
    end

    // Writes and stack moves take effect only when the instruction executes.
    always_comb begin
        wr_g       = exec.wr;
        wr_g.we    = exec.wr.we && fire;
        stk_g      = exec.stk;
        stk_g.push = exec.stk.push && fire;
        stk_g.pop  = exec.stk.pop && fire;
    end

    trc_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .i_wr      (wr_g),
        .o_rdata_a (opnd_a),
        .o_rdata_b (opnd_b)
    );

    trc_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_g),
        .o_count (count),
        .o_top   (top)
    );

    trc_exec #(
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_REGS    (NUM_REGS)
    ) u_exec (
        .i_instr  (r_instr),
        .i_state  (r_state),
        .i_opnd_a (opnd_a),
        .i_opnd_b (opnd_b),
        .i_count  (count),
        .i_top    (top),
        .o_exec   (exec)
    );

    // Program counter and status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{pc: 16'd0, stopped: 1'b0, fault: ERR_NONE};
        end else if (fire) begin
            r_state <= exec.nxt;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= exec.rsp;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_fetch_addr = r_out.fetch_addr;
    assign o_halted     = r_out.halted;
    assign o_error_code = r_out.error_code;
    assign o_dev_write  = r_out.dev_write;
    assign o_dev_port   = r_out.dev_port;
    assign o_dev_value  = r_out.dev_value;

    // Once stopped, the core stays stopped until reset.
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.stopped |=> r_state.stopped)
        else $error("core left the stopped state");

    // A fault is only ever recorded together with a stop.
    a_fault_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.fault != ERR_NONE) |-> r_state.stopped)
        else $error("fault recorded while running");

    // A stopped core changes no register and no stack entry.
    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.stopped |-> !(wr_g.we || stk_g.push || stk_g.pop))
        else $error("stopped core modified state");

endmodule

// File: tb/sv/tiny_register_cpu_core_tb.sv
// Self-checking testbench for the tiny register CPU core with a built-in instruction predictor.
module tiny_register_cpu_core_tb import trc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_COUNT      = 8;
    localparam int STACK_LIMIT    = 256;
    localparam int RANDOM_ITEMS   = 1810;
    localparam int STOPPED_ITEMS  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;

    // Above this address the random program draws only jumps.
    localparam logic [15:0] NEAR_TOP = 16'hfff0;

    localparam logic [7:0] ALU_OPS [6] = '{OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_EQU};
    localparam logic [7:0] REG_OPS [11] = '{OP_MOV, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR,
                                            OP_EQU, OP_JZ, OP_SHFT, OP_LDI, OP_DEO};

    // Ways the run is brought to a stop once the random part is done.
    typedef enum int {
        END_HALT,
        END_BAD_REG,
        END_PC_END,
        END_OVERFLOW,
        END_UNDERFLOW
    } t_ending;

    // One directed beat, with its result typed in where it is obvious.
    typedef struct packed {
        t_instr  ins;
        logic    has_want;
        t_result want;
    } t_directed_row;

    localparam t_result UNTYPED = '0;

    localparam t_directed_row DIRECTED_ROWS [25] = '{
        '{'{OP_NOP,  8'hff, 8'hff, 8'hff}, 1'b1, '{16'h0001, 1'b0, ERR_NONE, 1'b0, 8'h00, 8'h00}},
        '{'{OP_LDI,  8'd0,  8'hff, 8'h00}, 1'b0, UNTYPED},
        '{'{OP_LDI,  8'd7,  8'h01, 8'hff}, 1'b0, UNTYPED},
        '{'{OP_ADD,  8'd1,  8'd0,  8'd7 }, 1'b0, UNTYPED},
        '{'{OP_SUB,  8'd2,  8'd1,  8'd7 }, 1'b0, UNTYPED},
        '{'{OP_AND,  8'd3,  8'd0,  8'd7 }, 1'b0, UNTYPED},
        '{'{OP_OR,   8'd4,  8'd3,  8'd1 }, 1'b0, UNTYPED},
        '{'{OP_XOR,  8'd5,  8'd0,  8'd3 }, 1'b0, UNTYPED},
        '{'{OP_EQU,  8'd6,  8'd0,  8'd2 }, 1'b0, UNTYPED},
        '{'{OP_EQU,  8'd6,  8'd0,  8'd3 }, 1'b0, UNTYPED},
        '{'{OP_SHFT, 8'd5,  8'h00, 8'hff}, 1'b0, UNTYPED},
        '{'{OP_SHFT, 8'd0,  8'h80, 8'h00}, 1'b0, UNTYPED},
        '{'{OP_MOV,  8'd3,  8'd0,  8'hff}, 1'b0, UNTYPED},
        '{'{OP_DEO,  8'd2,  8'd1,  8'h00}, 1'b1, '{16'h002f, 1'b0, ERR_NONE, 1'b1, 8'hff, 8'h00}},
        '{'{OP_DEO,  8'd1,  8'd0,  8'hff}, 1'b0, UNTYPED},
        '{'{OP_JZ,   8'd0,  8'h12, 8'h34}, 1'b0, UNTYPED},
        '{'{OP_JZ,   8'd1,  8'h00, 8'h00}, 1'b1, '{16'h0000, 1'b0, ERR_NONE, 1'b0, 8'h00, 8'h00}},
        '{'{OP_JMP,  8'hff, 8'hfe, 8'hff}, 1'b1, '{16'hfffe, 1'b0, ERR_NONE, 1'b0, 8'h00, 8'h00}},
        '{'{OP_CALL, 8'h80, 8'h01, 8'h00}, 1'b1, '{16'h8001, 1'b0, ERR_NONE, 1'b0, 8'h00, 8'h00}},
        '{'{8'h10,   8'h00, 8'h00, 8'h00}, 1'b0, UNTYPED},
        '{'{OP_CALL, 8'hff, 8'hff, 8'h00}, 1'b0, UNTYPED},
        '{'{OP_RET,  8'h00, 8'h00, 8'h00}, 1'b0, UNTYPED},
        '{'{8'hff,   8'hff, 8'hff, 8'hff}, 1'b0, UNTYPED},
        '{'{OP_RET,  8'h00, 8'h00, 8'h00}, 1'b1, '{16'h0001, 1'b0, ERR_NONE, 1'b0, 8'h00, 8'h00}},
        '{'{OP_JMP,  8'h00, 8'h00, 8'h55}, 1'b1, '{16'h0000, 1'b0, ERR_NONE, 1'b0, 8'h00, 8'h00}}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_func;
    logic [7:0]  in_byte_one;
    logic [7:0]  in_byte_two;
    logic [7:0]  in_byte_three;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] out_fetch_addr;
    logic        out_halted;
    logic [2:0]  out_error_code;
    logic        out_dev_write;
    logic [7:0]  out_dev_port;
    logic [7:0]  out_dev_value;

    // Predicted machine state.
    logic [7:0]  gpr [REG_COUNT];
    logic [15:0] prog_addr;
    logic [15:0] ret_stack [STACK_LIMIT];
    int          stack_depth;
    logic        core_stopped;
    logic [2:0]  core_fault;

    t_result     pending_results [$];
    int          fail_count;
    int          idle_cycles;
    int          items_sent;
    bit          send_calm;
    bit          recv_calm;

    tiny_register_cpu_core dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_func       (in_func),
        .i_byte_one   (in_byte_one),
        .i_byte_two   (in_byte_two),
        .i_byte_three (in_byte_three),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_fetch_addr (out_fetch_addr),
        .o_halted     (out_halted),
        .o_error_code (out_error_code),
        .o_dev_write  (out_dev_write),
        .o_dev_port   (out_dev_port),
        .o_dev_value  (out_dev_value)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Execute one instruction on the predicted state and return its result beat.
    function automatic t_result execute_instr(input t_instr ins);
        t_result     res;
        logic [16:0] next_addr;
        logic [7:0]  lhs;
        logic [7:0]  rhs;
        logic [2:0]  len;
        logic        bad_reg;
        logic        jumped;
        logic        dev_wr;
        res     = '0;
        len     = LEN_ONE;
        bad_reg = 1'b0;
        jumped  = 1'b0;
        dev_wr  = 1'b0;
        if (!core_stopped) begin
            case (ins.func)
                OP_HALT: begin
                    core_stopped = 1'b1;
                    jumped       = 1'b1;
                end
                OP_MOV: begin
                    bad_reg = (ins.byte_one >= REG_COUNT) || (ins.byte_two >= REG_COUNT);
                    if (!bad_reg) gpr[ins.byte_one] = gpr[ins.byte_two];
                    len = LEN_THREE;
                end
                OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_EQU: begin
                    bad_reg = (ins.byte_one >= REG_COUNT) || (ins.byte_two >= REG_COUNT) ||
                              (ins.byte_three >= REG_COUNT);
                    if (!bad_reg) begin
                        lhs = gpr[ins.byte_two];
                        rhs = gpr[ins.byte_three];
                        case (ins.func)
                            OP_ADD:  gpr[ins.byte_one] = lhs + rhs;
                            OP_SUB:  gpr[ins.byte_one] = lhs - rhs;
                            OP_AND:  gpr[ins.byte_one] = lhs & rhs;
                            OP_OR:   gpr[ins.byte_one] = lhs | rhs;
                            OP_XOR:  gpr[ins.byte_one] = lhs ^ rhs;
                            default: gpr[ins.byte_one] = (lhs == rhs) ? 8'd1 : 8'd0;
                        endcase
                    end
                    len = LEN_FOUR;
                end
                OP_JMP: begin
                    prog_addr = {ins.byte_one, ins.byte_two};
                    jumped    = 1'b1;
                end
                OP_JZ: begin
                    bad_reg = ins.byte_one >= REG_COUNT;
                    if (!bad_reg && gpr[ins.byte_one] == 8'd0) begin
                        prog_addr = {ins.byte_two, ins.byte_three};
                        jumped    = 1'b1;
                    end
                    len = LEN_FOUR;
                end
                OP_SHFT: begin
                    bad_reg = ins.byte_one >= REG_COUNT;
                    if (!bad_reg) begin
                        if (ins.byte_two == 8'd0) gpr[ins.byte_one] = gpr[ins.byte_one] >> 1;
                        else gpr[ins.byte_one] = gpr[ins.byte_one] << 1;
                    end
                    len = LEN_THREE;
                end
                OP_LDI: begin
                    bad_reg = ins.byte_one >= REG_COUNT;
                    if (!bad_reg) gpr[ins.byte_one] = ins.byte_two;
                    len = LEN_THREE;
                end
                OP_DEO: begin
                    bad_reg = (ins.byte_one >= REG_COUNT) || (ins.byte_two >= REG_COUNT);
                    if (!bad_reg) begin
                        dev_wr        = 1'b1;
                        res.dev_port  = gpr[ins.byte_one];
                        res.dev_value = gpr[ins.byte_two];
                    end
                    len = LEN_THREE;
                end
                OP_CALL: begin
                    if (stack_depth >= STACK_LIMIT) begin
                        core_stopped = 1'b1;
                        core_fault   = ERR_OVERFLOW;
                    end else begin
                        ret_stack[stack_depth] = prog_addr + 16'd3;
                        stack_depth++;
                        prog_addr = {ins.byte_one, ins.byte_two};
                    end
                    jumped = 1'b1;
                end
                OP_RET: begin
                    if (stack_depth == 0) begin
                        core_stopped = 1'b1;
                        core_fault   = ERR_UNDERFLOW;
                    end else begin
                        stack_depth--;
                        prog_addr = ret_stack[stack_depth];
                    end
                    jumped = 1'b1;
                end
                // No-op and every opcode above the defined set.
                default: ;
            endcase

            // A bad operand cancels the instruction; otherwise step past it unless it
            // would run off the end of memory.
            if (bad_reg) begin
                core_stopped = 1'b1;
                core_fault   = ERR_BAD_REG;
            end else if (!jumped) begin
                next_addr = {1'b0, prog_addr} + 17'(len);
                if (next_addr > ADDR_LAST) begin
                    core_stopped = 1'b1;
                    core_fault   = ERR_PC_END;
                end else begin
                    prog_addr = next_addr[15:0];
                end
            end
        end
        res.fetch_addr = prog_addr;
        res.halted     = core_stopped;
        res.error_code = core_fault;
        res.dev_write  = dev_wr;
        return res;
    endfunction

    function automatic logic [7:0] rand_reg();
        return 8'($urandom_range(0, REG_COUNT - 1));
    endfunction

    // Jump targets lean on address zero and the last few bytes of memory.
    function automatic logic [15:0] rand_target();
        if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 2) == 0) return 16'h0000;
            return 16'($urandom_range(16'hfffc, 16'hffff));
        end
        return 16'($urandom);
    endfunction

    // Draw a well-formed instruction that keeps the core running from its current state.
    function automatic t_instr pick_running_instr();
        t_instr      ins;
        logic [15:0] target;
        int          roll;
        ins.func       = OP_NOP;
        ins.byte_one   = 8'($urandom);
        ins.byte_two   = 8'($urandom);
        ins.byte_three = 8'($urandom);
        target         = rand_target();
        roll           = $urandom_range(0, 99);
        if (prog_addr > NEAR_TOP) roll = 64 + 4 * $urandom_range(0, 2);
        if (roll < 8) begin
            ins.func     = OP_LDI;
            ins.byte_one = rand_reg();
        end else if (roll < 38) begin
            ins.func       = ALU_OPS[$urandom_range(0, 5)];
            ins.byte_one   = rand_reg();
            ins.byte_two   = rand_reg();
            ins.byte_three = rand_reg();
        end else if (roll < 43) begin
            ins.func     = OP_MOV;
            ins.byte_one = rand_reg();
            ins.byte_two = rand_reg();
        end else if (roll < 48) begin
            ins.func     = OP_SHFT;
            ins.byte_one = rand_reg();
            if ($urandom_range(0, 1) == 0) ins.byte_two = 8'h00;
        end else if (roll < 56) begin
            ins.func     = OP_DEO;
            ins.byte_one = rand_reg();
            ins.byte_two = rand_reg();
        end else if (roll < 64) begin
            ins.func       = OP_JZ;
            ins.byte_one   = rand_reg();
            ins.byte_two   = target[15:8];
            ins.byte_three = target[7:0];
        end else if (roll < 84) begin
            // Jumps: a call needs room on the stack, a return needs an entry on it.
            ins.func = OP_JMP;
            if (roll >= 72 && stack_depth > 0) ins.func = OP_RET;
            else if (roll >= 68 && stack_depth < STACK_LIMIT) ins.func = OP_CALL;
            ins.byte_one = target[15:8];
            ins.byte_two = target[7:0];
        end else if (roll >= 90) begin
            ins.func = 8'($urandom_range(16, 255));
        end
        return ins;
    endfunction

    // Offer one instruction beat, then record what it should produce once it is taken.
    task automatic send_instr(input t_instr ins, input logic has_want, input t_result want);
        t_result predicted;
        int      gap;
        if (items_sent % 100 == 0) send_calm = ($urandom_range(0, 3) == 0);
        gap = send_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_func       <= ins.func;
        in_byte_one   <= ins.byte_one;
        in_byte_two   <= ins.byte_two;
        in_byte_three <= ins.byte_three;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        predicted = execute_instr(ins);
        pending_results.push_back(has_want ? want : predicted);
    endtask

    task automatic send_random(input t_instr ins);
        send_instr(ins, 1'b0, UNTYPED);
    endtask

    // Stimulus: reset, directed table, random program, then one way of stopping the core.
    initial begin : stimulus
        t_instr      ins;
        t_instr      last;
        t_ending     ending;
        logic [16:0] spot;
        int          pos;
        in_valid      <= 1'b0;
        in_func       <= 8'h00;
        in_byte_one   <= 8'h00;
        in_byte_two   <= 8'h00;
        in_byte_three <= 8'h00;
        rst_n         <= 1'b0;
        for (int i = 0; i < REG_COUNT; i++) gpr[i] = 8'h00;
        for (int i = 0; i < STACK_LIMIT; i++) ret_stack[i] = 16'h0000;
        prog_addr    = 16'h0000;
        stack_depth  = 0;
        core_stopped = 1'b0;
        core_fault   = ERR_NONE;
        fail_count   = 0;
        items_sent   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            send_instr(DIRECTED_ROWS[i].ins, DIRECTED_ROWS[i].has_want, DIRECTED_ROWS[i].want);
        end

        repeat (RANDOM_ITEMS) send_random(pick_running_instr());

        ending = t_ending'($urandom_range(0, 4));
        ins    = t_instr'($urandom);
        case (ending)
            END_HALT: begin
                ins.func = OP_HALT;
                send_random(ins);
            end
            END_BAD_REG: begin
                // Valid operands everywhere except one, which points past the register file.
                ins.func       = REG_OPS[$urandom_range(0, 10)];
                ins.byte_one   = rand_reg();
                ins.byte_two   = rand_reg();
                ins.byte_three = rand_reg();
                case (ins.func)
                    OP_MOV, OP_DEO: pos = $urandom_range(0, 1);
                    OP_JZ, OP_SHFT, OP_LDI: pos = 0;
                    default: pos = $urandom_range(0, 2);
                endcase
                if (pos == 0) ins.byte_one = 8'($urandom_range(REG_COUNT, 255));
                else if (pos == 1) ins.byte_two = 8'($urandom_range(REG_COUNT, 255));
                else ins.byte_three = 8'($urandom_range(REG_COUNT, 255));
                send_random(ins);
            end
            END_PC_END: begin
                // Jump so that the address after the next instruction lies past the top.
                case ($urandom_range(0, 3))
                    0: begin
                        last = '{OP_NOP, 8'($urandom), 8'($urandom), 8'($urandom)};
                        spot = 17'h10000 - 17'(LEN_ONE);
                    end
                    1: begin
                        last = '{OP_DEO, rand_reg(), rand_reg(), 8'($urandom)};
                        spot = 17'h10000 - 17'(LEN_THREE) + 17'($urandom_range(0, 2));
                    end
                    2: begin
                        last = '{OP_LDI, rand_reg(), 8'($urandom), 8'($urandom)};
                        spot = 17'h10000 - 17'(LEN_THREE) + 17'($urandom_range(0, 2));
                    end
                    default: begin
                        last = '{ALU_OPS[$urandom_range(0, 5)], rand_reg(), rand_reg(), rand_reg()};
                        spot = 17'h10000 - 17'(LEN_FOUR) + 17'($urandom_range(0, 3));
                    end
                endcase
                send_random('{OP_JMP, spot[15:8], spot[7:0], 8'($urandom)});
                send_random(last);
            end
            END_OVERFLOW: begin
                while (stack_depth < STACK_LIMIT) begin
                    ins          = t_instr'($urandom);
                    ins.func     = OP_CALL;
                    send_random(ins);
                end
                ins.func = OP_CALL;
                send_random(ins);
            end
            default: begin
                while (stack_depth > 0) begin
                    ins      = t_instr'($urandom);
                    ins.func = OP_RET;
                    send_random(ins);
                end
                ins.func = OP_RET;
                send_random(ins);
            end
        endcase

        // Anything after the stop must leave the core frozen.
        repeat (STOPPED_ITEMS) send_random(t_instr'($urandom));
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Result side: stall at random, then check each beat against the oldest prediction.
    initial begin : result_sink
        t_result got;
        t_result want;
        int      stall;
        int      results_seen;
        results_seen = 0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (results_seen % 100 == 0) recv_calm = ($urandom_range(0, 3) == 0);
            stall = recv_calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            results_seen++;
            got = '{out_fetch_addr, out_halted, out_error_code, out_dev_write,
                    out_dev_port, out_dev_value};
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("%0t: result beat with nothing expected, fetch_addr=%h", $realtime,
                             got.fetch_addr);
                end
            end else begin
                want = pending_results.pop_front();
                if (got.fetch_addr !== want.fetch_addr || got.halted !== want.halted ||
                    got.error_code !== want.error_code || got.dev_write !== want.dev_write ||
                    got.dev_port !== want.dev_port || got.dev_value !== want.dev_value) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch expected addr=%h halt=%b err=%0d wr=%b port=%h val=%h",
                                 $realtime, want.fetch_addr, want.halted, want.error_code,
                                 want.dev_write, want.dev_port, want.dev_value);
                        $display("%0t:          actual   addr=%h halt=%b err=%0d wr=%b port=%h val=%h",
                                 $realtime, got.fetch_addr, got.halted, got.error_code,
                                 got.dev_write, got.dev_port, got.dev_value);
                    end
                end
            end
        end
    end

    // Watchdog: give up when no beat moves on either side for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// File: tiny_register_cpu_core.f
rtl/core/trc_pkg.sv
rtl/core/trc_regfile.sv
rtl/core/trc_stack.sv
rtl/core/trc_exec.sv
rtl/core/tiny_register_cpu_core.sv
tb/sv/tiny_register_cpu_core_tb.sv
